/* rtl/rms_pkg.sv */
// Package: shared types and constants of the robot mission sequencer.
`default_nettype none

package rms_pkg;

  // Battery averaging
  localparam int unsigned SAMPLES     = 4;
  localparam int unsigned IDX_W       = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned SUM_W       = 8 + $clog2(SAMPLES);
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  // floor(2^S / SAMPLES) + 1 gives an exact floor quotient over the full sum range
  localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'((1 << RECIP_SHIFT) / SAMPLES + 1);
  localparam logic [3:0] DIVIDE_LAST = 4'd9;

  // Mission constants
  localparam logic [7:0]  KEY_GO        = 8'h33;
  localparam logic [15:0] START_DIST    = 16'd150;
  localparam logic [15:0] NEAR_DIST     = 16'd40;
  localparam logic [3:0]  LOCKOUT_TICKS = 4'd10;

  // LED and/or masks
  localparam logic [7:0] LED_RESET      = 8'h02;
  localparam logic [7:0] LED_START_AND  = 8'hFD;
  localparam logic [7:0] LED_START_OR   = 8'h04;
  localparam logic [7:0] LED_STOP_AND   = 8'h21;
  localparam logic [7:0] LED_IDLE_OR    = 8'h02;
  localparam logic [7:0] LED_LOWBATT    = 8'h21;
  localparam logic [7:0] LED_TURN_AND   = 8'h7B;
  localparam logic [7:0] LED_TURN_OR    = 8'h48;
  localparam logic [7:0] LED_STRT_AND   = 8'h37;
  localparam logic [7:0] LED_STRT_OR    = 8'h10;
  localparam logic [7:0] LED_DONE_AND   = 8'h2F;

  // Command codes
  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CFG_SPEED_STRAIGHT = 3'd0;
  localparam logic [2:0] CFG_LEFT_OFFSET    = 3'd1;
  localparam logic [2:0] CFG_SPEED_ROTATE   = 3'd2;
  localparam logic [2:0] CFG_BATTERY_MIN    = 3'd3;
  localparam logic [2:0] CFG_ROTATE_TICKS   = 3'd4;
  localparam logic [2:0] CFG_STRAIGHT_TICKS = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_FORWARD  = 3'd1,
    PH_TURN     = 3'd2,
    PH_STRAIGHT = 3'd3,
    PH_LOWBATT  = 3'd4
  } phase_e;

  // Status from the battery monitor for the current tick
  typedef struct packed {
    logic conv;  // sample taken on this tick
    logic low;   // fresh average at or below the limit
  } bat_status_t;

endpackage

`default_nettype wire

/* rtl/robot_mission_sequencer.sv */
// Top level: mission phase sequencer with motor, LED and sensor request control.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------------
//   in      | input     | in_valid_i / in_ready_o   | cmd, key_byte, adc_sample, sonar_cm
//   out     | output    | out_valid_o / out_ready_i | pwm, turn, led, phase, battery, pulses
//   cfg     | input     | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
// One request per clock unless the output stalls: the whole update is computed
// in the accept cycle; the result appears in the output register on the next cycle.
// in_ready_o is high while the output register is empty or being taken, so
// a stall on the output holds back only the next request.
// Reset clears all control state; LED mask resets to 0x02, registers to defaults.
`default_nettype none

module robot_mission_sequencer
  import rms_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [7:0]  key_byte_i,
  input  wire logic [7:0]  adc_sample_i,
  input  wire logic [15:0] sonar_cm_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       left_pwm_o,
  output logic [7:0]       right_pwm_o,
  output logic             turn_dir_o,
  output logic [7:0]       led_drive_o,
  output logic [2:0]       phase_code_o,
  output logic             battery_alarm_o,
  output logic [7:0]       battery_level_o,
  output logic             start_conversion_o,
  output logic             sonar_trigger_o,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_wdata_i
);

  typedef struct packed {
    logic start;
    logic stop;
    logic low;
    logic turn;
    logic straight;
    logic done;
  } ev_t;

  // Configuration registers
  logic [7:0] speed_straight_q, left_offset_q, speed_rotate_q;
  logic [7:0] battery_min_q, rotate_ticks_q, straight_ticks_q;

  // Mission state
  phase_e      phase_q, phase_d, phase_mid;
  logic [7:0]  timer_q, timer_d;
  logic [3:0]  lock_q, lock_d;
  logic [15:0] dist_q, dist_d;
  logic [7:0]  left_q, left_d, right_q, right_d;
  logic        turning_q, turning_d;
  logic [7:0]  led_q, led_d;

  // Result register
  logic        out_valid_q;
  logic [7:0]  led_out_q, led_out_d;
  logic        conv_q, trig_q, trig_d;

  logic        fire, tick, key_go;
  ev_t         ev;
  bat_status_t bat;
  logic [7:0]  straight_left;

  assign in_ready_o    = !out_valid_q || out_ready_i;
  assign fire          = in_valid_i && in_ready_o;
  assign tick          = fire && (cmd_i == CMD_TICK);
  assign key_go        = key_byte_i == KEY_GO;
  assign straight_left = speed_straight_q + left_offset_q;

  rms_battery u_battery (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick),
    .adc_sample_i (adc_sample_i),
    .battery_min_i(battery_min_q),
    .status_o     (bat),
    .level_o      (battery_level_o),
    .alarm_o      (battery_alarm_o)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_straight_q <= 8'd128;
      left_offset_q    <= 8'd0;
      speed_rotate_q   <= 8'd100;
      battery_min_q    <= 8'd150;
      rotate_ticks_q   <= 8'd10;
      straight_ticks_q <= 8'd20;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SPEED_STRAIGHT: speed_straight_q <= cfg_wdata_i;
        CFG_LEFT_OFFSET:    left_offset_q    <= cfg_wdata_i;
        CFG_SPEED_ROTATE:   speed_rotate_q   <= cfg_wdata_i;
        CFG_BATTERY_MIN:    battery_min_q    <= cfg_wdata_i;
        CFG_ROTATE_TICKS:   rotate_ticks_q   <= cfg_wdata_i;
        CFG_STRAIGHT_TICKS: straight_ticks_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Next phase, timers and distance
  always_comb begin
    phase_d   = phase_q;
    phase_mid = phase_q;
    timer_d   = timer_q;
    lock_d    = lock_q;
    dist_d    = dist_q;
    trig_d    = 1'b0;
    ev        = '0;
    if (fire) begin
      if (cmd_i == CMD_KEY) begin
        if (key_go && dist_q >= START_DIST && phase_q == PH_IDLE) begin
          phase_d  = PH_FORWARD;
          lock_d   = LOCKOUT_TICKS;
          ev.start = 1'b1;
        end else if (key_go && lock_q == 4'd0 &&
                     (phase_q == PH_FORWARD || phase_q == PH_TURN ||
                      phase_q == PH_STRAIGHT)) begin
          phase_d = PH_IDLE;
          ev.stop = 1'b1;
        end
      end else begin
        if (lock_q != 4'd0) begin
          lock_d = lock_q - 4'd1;
        end
        if (bat.low) begin
          phase_mid = PH_LOWBATT;
          ev.low    = 1'b1;
        end
        phase_d = phase_mid;
        // sonar is read only when idle or driving forward
        if (phase_mid == PH_IDLE || phase_mid == PH_FORWARD) begin
          dist_d = sonar_cm_i;
          trig_d = 1'b1;
        end
        unique case (phase_mid)
          PH_FORWARD: begin
            if (dist_d < NEAR_DIST) begin
              phase_d = PH_TURN;
              timer_d = '0;
              ev.turn = 1'b1;
            end
          end
          PH_TURN: begin
            if (timer_q == rotate_ticks_q) begin
              phase_d     = PH_STRAIGHT;
              timer_d     = '0;
              ev.straight = 1'b1;
            end else begin
              timer_d = timer_q + 8'd1;
            end
          end
          PH_STRAIGHT: begin
            if (timer_q == straight_ticks_q) begin
              phase_d = PH_IDLE;
              ev.done = 1'b1;
            end else begin
              timer_d = timer_q + 8'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Motor duties and LED mask
  always_comb begin
    left_d    = left_q;
    right_d   = right_q;
    turning_d = turning_q;
    led_d     = led_q;
    led_out_d = '0;
    if (ev.start) begin
      left_d    = straight_left;
      right_d   = speed_straight_q;
      turning_d = 1'b0;
      led_d     = (led_q & LED_START_AND) | LED_START_OR;
    end
    if (ev.stop) begin
      left_d    = '0;
      right_d   = '0;
      turning_d = 1'b0;
      led_d     = (led_q & LED_STOP_AND) | LED_IDLE_OR;
    end
    // low battery stops motors but leaves the turn flag
    if (ev.low) begin
      left_d  = '0;
      right_d = '0;
      led_d   = LED_LOWBATT;
    end
    // LEDs show the mask after the battery check, before the phase change
    if (tick) begin
      led_out_d = led_d;
    end
    if (ev.turn) begin
      left_d    = speed_rotate_q;
      right_d   = speed_rotate_q;
      turning_d = 1'b1;
      led_d     = (led_d & LED_TURN_AND) | LED_TURN_OR;
    end
    if (ev.straight) begin
      left_d    = straight_left;
      right_d   = speed_straight_q;
      turning_d = 1'b0;
      led_d     = (led_d & LED_STRT_AND) | LED_STRT_OR;
    end
    if (ev.done) begin
      left_d    = '0;
      right_d   = '0;
      turning_d = 1'b0;
      led_d     = (led_d & LED_DONE_AND) | LED_IDLE_OR;
    end
  end

  // State registers, loaded together with the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      timer_q   <= '0;
      lock_q    <= '0;
      dist_q    <= '0;
      left_q    <= '0;
      right_q   <= '0;
      turning_q <= 1'b0;
      led_q     <= LED_RESET;
    end else if (fire) begin
      phase_q   <= phase_d;
      timer_q   <= timer_d;
      lock_q    <= lock_d;
      dist_q    <= dist_d;
      left_q    <= left_d;
      right_q   <= right_d;
      turning_q <= turning_d;
      led_q     <= led_d;
    end
  end

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Per-request result fields
  always_ff @(posedge clk_i) begin
    if (fire) begin
      led_out_q <= led_out_d;
      conv_q    <= bat.conv;
      trig_q    <= trig_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign left_pwm_o         = left_q;
  assign right_pwm_o        = right_q;
  assign turn_dir_o         = turning_q;
  assign led_drive_o        = led_out_q;
  assign phase_code_o       = phase_q;
  assign start_conversion_o = conv_q;
  assign sonar_trigger_o    = trig_q;

endmodule

`default_nettype wire

/* rtl/rms_battery.sv */
// Battery monitor: tick divider, sample store, floor average and alarm latch.
`default_nettype none

module rms_battery
  import rms_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        tick_i,
  input  wire logic [7:0]  adc_sample_i,
  input  wire logic [7:0]  battery_min_i,
  output bat_status_t      status_o,
  output logic [7:0]       level_o,
  output logic             alarm_o
);

  logic [3:0]        div_q, div_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [7:0]        store_q [SAMPLES];
  logic [7:0]        avg_q, avg_d;
  logic              alarm_q, alarm_d;

  logic              take;
  logic [IDX_W:0]    cnt_nxt;
  logic              wrap;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W+RECIP_W-1:0] prod;
  logic [7:0]        avg_new;

  assign take    = tick_i && (div_q >= DIVIDE_LAST);
  assign cnt_nxt = {1'b0, idx_q} + (IDX_W+1)'(1);
  assign wrap    = cnt_nxt >= (IDX_W+1)'(SAMPLES);

  // Sum including the sample being written this tick
  always_comb begin
    sum = '0;
    for (int i = 0; i < SAMPLES; i++) begin
      if (idx_q == IDX_W'(i)) begin
        sum = sum + SUM_W'(adc_sample_i);
      end else begin
        sum = sum + SUM_W'(store_q[i]);
      end
    end
  end

  // Floor divide by reciprocal multiply
  assign prod    = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(RECIP_MUL);
  assign avg_new = prod[RECIP_SHIFT +: 8];

  // Next state
  always_comb begin
    div_d    = div_q;
    idx_d    = idx_q;
    avg_d    = avg_q;
    alarm_d  = alarm_q;
    status_o = '0;
    if (tick_i) begin
      if (take) begin
        div_d         = '0;
        status_o.conv = 1'b1;
        if (wrap) begin
          idx_d = '0;
          avg_d = avg_new;
          if (avg_new <= battery_min_i) begin
            alarm_d      = 1'b1;
            status_o.low = 1'b1;
          end
        end else begin
          idx_d = cnt_nxt[IDX_W-1:0];
        end
      end else begin
        div_d = div_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q   <= '0;
      idx_q   <= '0;
      avg_q   <= '0;
      alarm_q <= 1'b0;
    end else begin
      div_q   <= div_d;
      idx_q   <= idx_d;
      avg_q   <= avg_d;
      alarm_q <= alarm_d;
    end
  end

  // Sample store, no reset: every entry is written before an average reads it
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SAMPLES; i++) begin
      if (take && idx_q == IDX_W'(i)) begin
        store_q[i] <= adc_sample_i;
      end
    end
  end

  assign level_o = avg_q;
  assign alarm_o = alarm_q;

endmodule

`default_nettype wire

/* bench/rms_checker.sv */
// Checker for the robot mission sequencer: tracks mission state and compares every result.
module rms_checker
  import rms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        cmd_i,
  input  logic [7:0]  key_byte_i,
  input  logic [7:0]  adc_sample_i,
  input  logic [15:0] sonar_cm_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  left_pwm_i,
  input  logic [7:0]  right_pwm_i,
  input  logic        turn_dir_i,
  input  logic [7:0]  led_drive_i,
  input  logic [2:0]  phase_code_i,
  input  logic        battery_alarm_i,
  input  logic [7:0]  battery_level_i,
  input  logic        start_conversion_i,
  input  logic        sonar_trigger_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  output int          results_pending_o,
  output int          mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register values after reset
  localparam logic [7:0] SPEED_STRAIGHT_RST = 8'd128;
  localparam logic [7:0] LEFT_OFFSET_RST    = 8'd0;
  localparam logic [7:0] SPEED_ROTATE_RST   = 8'd100;
  localparam logic [7:0] BATTERY_MIN_RST    = 8'd150;
  localparam logic [7:0] ROTATE_TICKS_RST   = 8'd10;
  localparam logic [7:0] STRAIGHT_TICKS_RST = 8'd20;

  typedef struct packed {
    logic [7:0] left_pwm;
    logic [7:0] right_pwm;
    logic       turn_dir;
    logic [7:0] led_drive;
    phase_e     phase_code;
    logic       battery_alarm;
    logic [7:0] battery_level;
    logic       start_conversion;
    logic       sonar_trigger;
  } motor_report_t;

  // Register copies
  logic [7:0] speed_straight, left_offset, speed_rotate;
  logic [7:0] battery_min, rotate_ticks, straight_ticks;

  // Mission state
  phase_e      phase;
  logic [7:0]  led_mask;
  logic [3:0]  lockout;
  logic [7:0]  phase_timer;
  logic [3:0]  divider;
  int unsigned sample_slot;
  logic [7:0]  samples [SAMPLES];
  logic [15:0] distance;
  logic [7:0]  left_duty, right_duty;
  logic        turning;
  logic        alarm;
  logic [7:0]  average;

  motor_report_t expected_reports [$];
  int            mismatches;

  assign mismatches_o = mismatches;

  function automatic void set_straight();
    left_duty  = speed_straight + left_offset;
    right_duty = speed_straight;
    turning    = 1'b0;
  endfunction

  function automatic void halt_motors();
    left_duty  = '0;
    right_duty = '0;
    turning    = 1'b0;
  endfunction

  // One request through the mission sequencer, yielding the report it causes
  task automatic advance_mission(input logic cmd, input logic [7:0] key,
                                 input logic [7:0] adc, input logic [15:0] sonar,
                                 output motor_report_t rpt);
    int unsigned sum;
    rpt = '0;
    if (cmd == CMD_KEY) begin
      if (key == KEY_GO && distance >= START_DIST && phase == PH_IDLE) begin
        phase = PH_FORWARD;
        set_straight();
        led_mask = (led_mask & LED_START_AND) | LED_START_OR;
        lockout  = LOCKOUT_TICKS;
      end else if (key == KEY_GO && phase inside {PH_FORWARD, PH_TURN, PH_STRAIGHT}
                   && lockout == '0) begin
        halt_motors();
        phase    = PH_IDLE;
        led_mask = (led_mask & LED_STOP_AND) | LED_IDLE_OR;
      end
    end else begin
      if (lockout != '0) lockout--;

      // battery sampling every tenth tick, averaged over a full store
      if (divider >= DIVIDE_LAST) begin
        divider = '0;
        samples[sample_slot] = adc;
        sample_slot++;
        if (sample_slot >= SAMPLES) begin
          sum = 0;
          for (int k = 0; k < SAMPLES; k++) sum += samples[k];
          average = 8'(sum / SAMPLES);
          if (average <= battery_min) begin
            alarm      = 1'b1;
            left_duty  = '0;
            right_duty = '0;
            phase      = PH_LOWBATT;
            led_mask   = LED_LOWBATT;
          end
          sample_slot = 0;
        end
        rpt.start_conversion = 1'b1;
      end else begin
        divider++;
      end

      // LEDs show the mask before this tick's phase change
      rpt.led_drive = led_mask;

      if (phase == PH_IDLE || phase == PH_FORWARD) begin
        distance          = sonar;
        rpt.sonar_trigger = 1'b1;
      end

      if (phase == PH_FORWARD && distance < NEAR_DIST) begin
        phase       = PH_TURN;
        led_mask    = (led_mask & LED_TURN_AND) | LED_TURN_OR;
        phase_timer = '0;
        left_duty   = speed_rotate;
        right_duty  = speed_rotate;
        turning     = 1'b1;
      end else if (phase == PH_TURN) begin
        if (phase_timer == rotate_ticks) begin
          phase       = PH_STRAIGHT;
          led_mask    = (led_mask & LED_STRT_AND) | LED_STRT_OR;
          phase_timer = '0;
          set_straight();
        end else begin
          phase_timer++;
        end
      end else if (phase == PH_STRAIGHT) begin
        if (phase_timer == straight_ticks) begin
          halt_motors();
          phase    = PH_IDLE;
          led_mask = (led_mask & LED_DONE_AND) | LED_IDLE_OR;
        end else begin
          phase_timer++;
        end
      end
    end

    rpt.left_pwm      = left_duty;
    rpt.right_pwm     = right_duty;
    rpt.turn_dir      = turning;
    rpt.phase_code    = phase;
    rpt.battery_alarm = alarm;
    rpt.battery_level = average;
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endtask

  initial mismatches = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    motor_report_t want, rpt;
    if (!rst_ni) begin
      speed_straight = SPEED_STRAIGHT_RST;
      left_offset    = LEFT_OFFSET_RST;
      speed_rotate   = SPEED_ROTATE_RST;
      battery_min    = BATTERY_MIN_RST;
      rotate_ticks   = ROTATE_TICKS_RST;
      straight_ticks = STRAIGHT_TICKS_RST;
      phase          = PH_IDLE;
      led_mask       = LED_RESET;
      lockout        = '0;
      phase_timer    = '0;
      divider        = '0;
      sample_slot    = 0;
      distance       = '0;
      left_duty      = '0;
      right_duty     = '0;
      turning        = 1'b0;
      alarm          = 1'b0;
      average        = '0;
      expected_reports.delete();
      results_pending_o <= 0;
    end else begin
      // compare a taken result against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("left_pwm", want.left_pwm, left_pwm_i);
          check_field("right_pwm", want.right_pwm, right_pwm_i);
          check_field("turn_dir", want.turn_dir, turn_dir_i);
          check_field("led_drive", want.led_drive, led_drive_i);
          check_field("phase_code", want.phase_code, phase_code_i);
          check_field("battery_alarm", want.battery_alarm, battery_alarm_i);
          check_field("battery_level", want.battery_level, battery_level_i);
          check_field("start_conversion", want.start_conversion, start_conversion_i);
          check_field("sonar_trigger", want.sonar_trigger, sonar_trigger_i);
        end
      end

      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SPEED_STRAIGHT: speed_straight = cfg_wdata_i;
          CFG_LEFT_OFFSET:    left_offset    = cfg_wdata_i;
          CFG_SPEED_ROTATE:   speed_rotate   = cfg_wdata_i;
          CFG_BATTERY_MIN:    battery_min    = cfg_wdata_i;
          CFG_ROTATE_TICKS:   rotate_ticks   = cfg_wdata_i;
          CFG_STRAIGHT_TICKS: straight_ticks = cfg_wdata_i;
          default: ;
        endcase
      end

      // accepted request
      if (in_valid_i && in_ready_i) begin
        advance_mission(cmd_i, key_byte_i, adc_sample_i, sonar_cm_i, rpt);
        expected_reports.push_back(rpt);
      end

      results_pending_o <= expected_reports.size();
    end
  end

endmodule

/* bench/tb_top.sv */
// Testbench top: drives requests and register writes into the sequencer and reports the verdict.
module tb_top
  import rms_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 3000;  // cycles without any handshake
  localparam int SETTLE       = 4;     // cycles after the last result
  localparam int HOLD_CYCLES  = 80;    // long receiver hold-off

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid, in_ready;
  logic        cmd;
  logic [7:0]  key_byte, adc_sample;
  logic [15:0] sonar_cm;
  logic        out_valid, out_ready;
  logic [7:0]  left_pwm, right_pwm, led_drive, battery_level;
  logic        turn_dir, battery_alarm, start_conversion, sonar_trigger;
  logic [2:0]  phase_code;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [7:0]  cfg_wdata;
  int          results_pending, mismatches;

  // stimulus state
  logic [7:0]  settings [6];
  int          burst_left;
  int          adc_floor;
  logic        hold_request;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  robot_mission_sequencer DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .cmd_i              (cmd),
    .key_byte_i         (key_byte),
    .adc_sample_i       (adc_sample),
    .sonar_cm_i         (sonar_cm),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .left_pwm_o         (left_pwm),
    .right_pwm_o        (right_pwm),
    .turn_dir_o         (turn_dir),
    .led_drive_o        (led_drive),
    .phase_code_o       (phase_code),
    .battery_alarm_o    (battery_alarm),
    .battery_level_o    (battery_level),
    .start_conversion_o (start_conversion),
    .sonar_trigger_o    (sonar_trigger),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata)
  );

  rms_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .cmd_i              (cmd),
    .key_byte_i         (key_byte),
    .adc_sample_i       (adc_sample),
    .sonar_cm_i         (sonar_cm),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .left_pwm_i         (left_pwm),
    .right_pwm_i        (right_pwm),
    .turn_dir_i         (turn_dir),
    .led_drive_i        (led_drive),
    .phase_code_i       (phase_code),
    .battery_alarm_i    (battery_alarm),
    .battery_level_i    (battery_level),
    .start_conversion_i (start_conversion),
    .sonar_trigger_i    (sonar_trigger),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .results_pending_o  (results_pending),
    .mismatches_o       (mismatches)
  );

  // ADC values stay above every battery limit used until the final phase
  function automatic logic [7:0] pick_adc();
    return 8'($urandom_range(255, adc_floor));
  endfunction

  // Offer one request in bursts with random gaps, then wait for acceptance
  task automatic offer_request(input logic c, input logic [7:0] key,
                               input logic [7:0] adc, input logic [15:0] sonar);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid   <= 1'b1;
    cmd        <= c;
    key_byte   <= key;
    adc_sample <= adc;
    sonar_cm   <= sonar;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic tick_req(input logic [15:0] sonar);
    offer_request(CMD_TICK, 8'($urandom), pick_adc(), sonar);
  endtask

  task automatic key_req(input logic [7:0] key);
    offer_request(CMD_KEY, key, pick_adc(), 16'($urandom));
  endtask

  // Stop offering and wait until every result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic load_settings();
    for (int r = 0; r < 6; r++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= 3'(r);
      cfg_wdata <= settings[r];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic shuffle_settings(input logic [7:0] min_level);
    settings[CFG_SPEED_STRAIGHT] = 8'($urandom);
    settings[CFG_LEFT_OFFSET]    = 8'($urandom);
    settings[CFG_SPEED_ROTATE]   = 8'($urandom);
    settings[CFG_BATTERY_MIN]    = min_level;
    settings[CFG_ROTATE_TICKS]   = 8'($urandom_range(0, 12));
    settings[CFG_STRAIGHT_TICKS] = 8'($urandom_range(0, 12));
    load_settings();
  endtask

  // Mostly complete runs (arm, start, approach, turn, straight) plus random noise
  task automatic run_missions(input int quota);
    int sent, fwd, tail, roll;
    sent = 0;
    while (sent < quota) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        tick_req(16'($urandom_range(65535, 150)));
        key_req(KEY_GO);
        fwd = $urandom_range(0, 4);
        repeat (fwd) tick_req(16'($urandom_range(65535, 40)));
        tick_req(16'($urandom_range(39, 0)));
        tail = $urandom_range(0, settings[CFG_ROTATE_TICKS] + settings[CFG_STRAIGHT_TICKS] + 3);
        if (tail > 40) tail = 40;
        for (int t = 0; t < tail; t++) begin
          // occasional stop key, sometimes still inside the lockout
          if ($urandom_range(0, 9) == 0) key_req(KEY_GO);
          else tick_req(16'($urandom));
        end
        sent += 3 + fwd + tail;
      end else begin
        offer_request(1'($urandom), (roll < 85) ? KEY_GO : 8'($urandom), pick_adc(),
                      16'($urandom));
        sent++;
      end
    end
  endtask

  // Receiver: ready pattern changes mode now and then, one long hold-off on request
  initial begin : result_sink
    int mode, mode_left, hold_left;
    logic hold_taken;
    out_ready = 1'b0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    hold_taken = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog: ends the run when no handshake happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("robot_mission_sequencer test failed");
    $finish;
  end

  initial begin : stimulus
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    cmd          = CMD_KEY;
    key_byte     = '0;
    adc_sample   = '0;
    sonar_cm     = '0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_SPEED_STRAIGHT;
    cfg_wdata    = '0;
    burst_left   = 0;
    adc_floor    = 151;
    hold_request = 1'b0;
    settings[CFG_SPEED_STRAIGHT] = 8'd128;
    settings[CFG_LEFT_OFFSET]    = 8'd0;
    settings[CFG_SPEED_ROTATE]   = 8'd100;
    settings[CFG_BATTERY_MIN]    = 8'd150;
    settings[CFG_ROTATE_TICKS]   = 8'd10;
    settings[CFG_STRAIGHT_TICKS] = 8'd20;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: start conditions, lockout, approach and stop by key
    key_req(KEY_GO);               // distance still zero
    tick_req(16'd149);
    key_req(KEY_GO);               // just short of the start distance
    tick_req(16'd150);
    key_req(8'h32);                // foreign key code
    key_req(KEY_GO);               // start
    key_req(KEY_GO);               // stop held off by the lockout
    tick_req(16'hFFFF);
    tick_req(16'd40);
    tick_req(16'd39);              // obstacle: begin turning
    repeat (7) tick_req(16'($urandom));
    key_req(KEY_GO);               // lockout expired: stop while turning
    key_req(8'h00);
    key_req(8'hFF);
    run_missions(30);
    wait_idle();

    // low extremes: zero duties, one-tick turn and straight phases
    foreach (settings[r]) settings[r] = 8'd0;
    load_settings();
    tick_req(16'd300);
    key_req(KEY_GO);
    tick_req(16'd0);
    tick_req(16'($urandom));
    tick_req(16'($urandom));
    run_missions(20);
    wait_idle();

    // high extremes: wrapping left duty and the longest turn and straight phases
    settings[CFG_SPEED_STRAIGHT] = 8'd255;
    settings[CFG_LEFT_OFFSET]    = 8'd255;
    settings[CFG_SPEED_ROTATE]   = 8'd255;
    settings[CFG_BATTERY_MIN]    = 8'd150;
    settings[CFG_ROTATE_TICKS]   = 8'd255;
    settings[CFG_STRAIGHT_TICKS] = 8'd255;
    load_settings();
    tick_req(16'hFFFF);
    key_req(KEY_GO);
    tick_req(16'd0);
    repeat (515) tick_req(16'($urandom));
    run_missions(10);
    wait_idle();

    // random settings, with the long receiver hold-off in the first set
    shuffle_settings(8'($urandom_range(0, 150)));
    hold_request = 1'b1;
    run_missions(30);
    wait_idle();
    shuffle_settings(8'($urandom_range(0, 150)));
    run_missions(30);
    wait_idle();

    // battery limit at the top: low battery is reached and is terminal
    adc_floor = 0;
    shuffle_settings(8'd255);
    run_missions(20);
    repeat (45) tick_req(16'($urandom));
    key_req(KEY_GO);
    tick_req(16'd200);
    key_req(KEY_GO);
    wait_idle();

    if (mismatches == 0) begin
      $display("robot_mission_sequencer test passed");
    end else begin
      $display("robot_mission_sequencer test failed");
    end
    $finish;
  end

endmodule
